// ----- hw/rtl/dlfp_pkg.sv -----
// Shared types, codes and character constants for the device list frame parser.
// Used by the parser, the result queue and the top level; depends on nothing.
package dlfp_pkg;

	localparam int DLFP_MAX_DEVICES = 16;

	// Result queue depth; a power of two so the pointers wrap on their own.
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);

	localparam logic [2:0] KIND_OKAY      = 3'd0;
	localparam logic [2:0] KIND_NAME_BYTE = 3'd1;
	localparam logic [2:0] KIND_NAME_END  = 3'd2;
	localparam logic [2:0] KIND_DONE      = 3'd3;
	localparam logic [2:0] KIND_HDR_ERR   = 3'd4;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;

	// "OKAY" with the first character in the top byte.
	localparam logic [31:0] TOK_OKAY = 32'h4F4B_4159;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] name_byte;
		logic [3:0] dev_idx;
		logic [4:0] device_count;
		logic       last_result;
	} result_t;

	// Up to two results produced by one word; count says how many are meaningful.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} result_pair_t;

	// Returns {valid, nibble} for one ASCII hex digit of either case.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] diff;
		logic [4:0] r;
		diff = '0;
		r = '0;
		case (c) inside
			[CH_0:CH_9]: begin
				diff = c - CH_0;
				r = {1'b1, diff[3:0]};
			end
			[CH_UA:CH_UF]: begin
				diff = c - CH_UA + 8'd10;
				r = {1'b1, diff[3:0]};
			end
			[CH_LA:CH_LF_HEX]: begin
				diff = c - CH_LA + 8'd10;
				r = {1'b1, diff[3:0]};
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/dlfp_channels.sv -----
// Valid/ready channel interfaces for the parser's byte input and result output.
// Stand-alone; the payload fields match the package's result fields.
interface dlfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       chunk_last;

	modport source (output valid, output data_byte, output chunk_last, input ready);
	modport sink (input valid, input data_byte, input chunk_last, output ready);
endinterface

interface dlfp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] name_byte;
	logic [3:0] dev_idx;
	logic [4:0] device_count;
	logic       last_result;

	modport source (output valid, output kind, output name_byte, output dev_idx,
		output device_count, output last_result, input ready);
	modport sink (input valid, input kind, input name_byte, input dev_idx,
		input device_count, input last_result, output ready);
endinterface

// ----- hw/rtl/dlfp_parser.sv -----
// Frame parser state and per-word decode: header tokens, payload lines, device count.
// Depends on dlfp_pkg.
module dlfp_parser import dlfp_pkg::*; #(
	parameter int MAX_DEVICES = DLFP_MAX_DEVICES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  logic [7:0]   data_byte,
	input  logic         chunk_last,
	output result_pair_t pair
);

	localparam int CW = $clog2(MAX_DEVICES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DEVICES);

	logic [23:0]   header_held_q, header_held_d;
	logic [1:0]    header_fill_q, header_fill_d;
	logic [15:0]   payload_left_q, payload_left_d;
	logic          in_payload_q, in_payload_d;
	logic          in_state_q, in_state_d;
	logic [CW-1:0] devices_seen_q, devices_seen_d;

	logic [31:0]   token;
	logic [4:0]    hd0, hd1, hd2, hd3;
	logic          all_hex;
	logic [15:0]   length;
	logic          a_vld, done_vld;
	logic [2:0]    a_kind;
	logic [7:0]    a_name;
	logic [CW-1:0] done_cnt;
	logic [CW+3:0] idx_ext;
	logic [CW+4:0] cnt_ext;
	result_t       a_res, done_res;

	assign token   = {header_held_q, data_byte};
	assign hd0     = hex_digit(token[31:24]);
	assign hd1     = hex_digit(token[23:16]);
	assign hd2     = hex_digit(token[15:8]);
	assign hd3     = hex_digit(token[7:0]);
	assign all_hex = hd0[4] & hd1[4] & hd2[4] & hd3[4];
	assign length  = {hd0[3:0], hd1[3:0], hd2[3:0], hd3[3:0]};
	assign idx_ext = {4'b0, devices_seen_q};

	always_comb begin
		header_held_d  = header_held_q;
		header_fill_d  = header_fill_q;
		payload_left_d = payload_left_q;
		in_payload_d   = in_payload_q;
		in_state_d     = in_state_q;
		devices_seen_d = devices_seen_q;
		a_vld    = 1'b0;
		a_kind   = KIND_OKAY;
		a_name   = '0;
		done_vld = 1'b0;
		done_cnt = '0;

		if (!in_payload_q) begin
			if (header_fill_q != 2'd3) begin
				header_held_d = {header_held_q[15:0], data_byte};
				header_fill_d = header_fill_q + 2'd1;
				// A chunk that ends inside a header throws the partial header away.
				if (chunk_last) begin
					header_held_d = '0;
					header_fill_d = '0;
				end
			end else begin
				header_held_d = '0;
				header_fill_d = '0;
				if (token == TOK_OKAY) begin
					a_vld  = 1'b1;
					a_kind = KIND_OKAY;
				end else if (!all_hex) begin
					a_vld  = 1'b1;
					a_kind = KIND_HDR_ERR;
				end else if (length == 16'd0) begin
					done_vld = 1'b1;
				end else begin
					in_payload_d   = 1'b1;
					payload_left_d = length;
					devices_seen_d = '0;
					in_state_d     = 1'b0;
				end
			end
		end else begin
			payload_left_d = payload_left_q - 16'd1;
			if (!in_state_q) begin
				if (data_byte == CH_TAB) begin
					if (devices_seen_q < MAX_CNT) begin
						a_vld  = 1'b1;
						a_kind = KIND_NAME_END;
					end
					in_state_d = 1'b1;
				end else if (devices_seen_q < MAX_CNT) begin
					a_vld  = 1'b1;
					a_kind = KIND_NAME_BYTE;
					a_name = data_byte;
				end
			end else if (data_byte == CH_LF) begin
				if (devices_seen_q < MAX_CNT) begin
					devices_seen_d = devices_seen_q + CW'(1);
				end
				in_state_d = 1'b0;
			end
			if (payload_left_d == 16'd0) begin
				// A line that got as far as its state field still counts.
				done_vld = 1'b1;
				done_cnt = devices_seen_d + CW'(in_state_d && (devices_seen_d < MAX_CNT));
				in_payload_d   = 1'b0;
				in_state_d     = 1'b0;
				devices_seen_d = '0;
			end
		end

		cnt_ext = {5'b0, done_cnt};

		a_res.kind         = a_kind;
		a_res.name_byte    = a_name;
		a_res.dev_idx      = (a_kind == KIND_NAME_BYTE || a_kind == KIND_NAME_END) ?
			idx_ext[3:0] : 4'd0;
		a_res.device_count = '0;
		a_res.last_result  = !done_vld;

		done_res.kind         = KIND_DONE;
		done_res.name_byte    = '0;
		done_res.dev_idx      = '0;
		done_res.device_count = cnt_ext[4:0];
		done_res.last_result  = 1'b1;

		pair.first  = a_vld ? a_res : done_res;
		pair.second = done_res;
		pair.count  = {1'b0, a_vld} + {1'b0, done_vld};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_held_q  <= '0;
			header_fill_q  <= '0;
			payload_left_q <= '0;
			in_payload_q   <= 1'b0;
			in_state_q     <= 1'b0;
			devices_seen_q <= '0;
		end else if (fire) begin
			header_held_q  <= header_held_d;
			header_fill_q  <= header_fill_d;
			payload_left_q <= payload_left_d;
			in_payload_q   <= in_payload_d;
			in_state_q     <= in_state_d;
			devices_seen_q <= devices_seen_d;
		end
	end

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (header_fill_q == 2'd0 && payload_left_q != 16'd0))
		else $error("payload active with header bytes held or no bytes left");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		devices_seen_q <= MAX_CNT)
		else $error("device count above its limit");

	a_payload_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && in_payload_q && payload_left_q == 16'd1) |=> !in_payload_q)
		else $error("payload did not close on its last word");

endmodule

// ----- hw/rtl/dlfp_result_fifo.sv -----
// Four-entry result queue that takes up to two results a cycle and hands out one.
// Depends on dlfp_pkg and the dlfp_out_if channel.
module dlfp_result_fifo import dlfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  result_pair_t pair,
	output logic         room,
	dlfp_out_if.source   results
);

	localparam logic [RES_PTR_W:0] ROOM_LIMIT = (RES_PTR_W + 1)'(RES_DEPTH - 2);
	localparam logic [RES_PTR_W:0] FULL_CNT   = (RES_PTR_W + 1)'(RES_DEPTH);

	result_t                slot_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wr_ptr_q, rd_ptr_q, wr_next;
	logic [RES_PTR_W:0]     count_q;
	logic [1:0]             push_n;
	logic                   pop;
	result_t                head;

	assign push_n  = push ? pair.count : 2'd0;
	assign pop     = results.valid && results.ready;
	assign wr_next = wr_ptr_q + RES_PTR_W'(1);
	assign room    = count_q <= ROOM_LIMIT;
	assign head    = slot_q[rd_ptr_q];

	assign results.valid        = count_q != '0;
	assign results.kind         = head.kind;
	assign results.name_byte    = head.name_byte;
	assign results.dev_idx      = head.dev_idx;
	assign results.device_count = head.device_count;
	assign results.last_result  = head.last_result;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			slot_q[wr_ptr_q] <= pair.first;
		end
		if (push_n == 2'd2) begin
			slot_q[wr_next] <= pair.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			count_q <= count_q + (RES_PTR_W + 1)'(push_n) - (RES_PTR_W + 1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("result queue overflow");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |=> results.valid)
		else $error("pushed result not presented");

	// A stalled result stays on the output unchanged until it is taken.
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.ready) |=> (results.valid && $stable(head)))
		else $error("stalled result changed before it was taken");

endmodule

// ----- hw/rtl/device_list_frame_parser_core.sv -----
// Top level of the device list frame parser: byte channel in, result channel out.
// Depends on dlfp_pkg, dlfp_channels, dlfp_parser and dlfp_result_fifo.
//
// An accepted word's results are registered into the result queue and shown in order.
// Throughput: one word per cycle while the input is ready; a word that causes two results
//   (last name byte or name end with the list count) hands them out one at a time.
// The input is ready whenever the four-entry result queue has at least two free slots.
// Reset (arst_n low) clears the parser state and empties the result queue.
module device_list_frame_parser_core import dlfp_pkg::*; #(
	parameter int MAX_DEVICES = DLFP_MAX_DEVICES
) (
	input  logic     clk,
	input  logic     arst_n,
	dlfp_in_if.sink  items,
	dlfp_out_if.source results
);

	// A word is taken only when the queue can absorb both results it might cause,
	// so the parser never has to stall mid-word.
	logic         room;
	logic         fire;
	result_pair_t pair;

	assign items.ready = room;
	assign fire        = items.valid && room;

	// Header assembly, payload line tracking and the device count live here.
	dlfp_parser #(
		.MAX_DEVICES(MAX_DEVICES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.data_byte  (items.data_byte),
		.chunk_last (items.chunk_last),
		.pair       (pair)
	);

	// The queue serializes result pairs onto the single output channel.
	dlfp_result_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fire),
		.pair    (pair),
		.room    (room),
		.results (results)
	);

endmodule
